/* hw/rtl/ptt_pkg.sv */
// Shared types and constants of the periodic task timer.
`default_nettype none
package ptt_pkg;

    localparam int TIME_W = 48;
    localparam int DROP_W = 32;
    localparam int RCNT_W = 32;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_CANCEL  = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [1:0] POL_CATCHUP = 2'd0;
    localparam logic [1:0] POL_TERM    = 2'd1;
    localparam logic [1:0] POL_DROP    = 2'd2;

    localparam logic [1:0] CLASS_OK   = 2'd0;
    localparam logic [1:0] CLASS_WARN = 2'd1;
    localparam logic [1:0] CLASS_ERR  = 2'd2;

    localparam logic [1:0] END_RUN    = 2'd0;
    localparam logic [1:0] END_DONE   = 2'd1;
    localparam logic [1:0] END_BEHIND = 2'd2;

    localparam logic [2:0] REG_START    = 3'd0;
    localparam logic [2:0] REG_INTERVAL = 3'd1;
    localparam logic [2:0] REG_COUNT    = 3'd2;
    localparam logic [2:0] REG_FOREVER  = 3'd3;
    localparam logic [2:0] REG_POLICY   = 3'd4;
    localparam logic [2:0] REG_WARN     = 3'd5;
    localparam logic [2:0] REG_FAIL     = 3'd6;
    localparam logic [2:0] REG_WEN      = 3'd7;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] now_time;
    } in_t;

    typedef struct packed {
        logic [TIME_W-1:0] lateness;
        logic [1:0]        late_class;
        logic [DROP_W-1:0] dropped_count;
        logic              drop_warning;
        logic [1:0]        end_reason;
        logic [TIME_W-1:0] next_due;
        logic              last_fire;
    } out_t;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] repeat_interval;
        logic [RCNT_W-1:0] repeat_count;
        logic              repeat_forever;
        logic [1:0]        missed_policy;
        logic [TIME_W-1:0] warning_slop;
        logic [TIME_W-1:0] fail_slop;
        logic              warnings_enable;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic fire;
        logic check;
        logic drop;
        logic eval;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic cond;
        logic div_go;
        logic div_done;
        logic out_free;
        logic last;
    } stat_t;

endpackage
`default_nettype wire

/* hw/rtl/ptt_regs.sv */
// APB configuration register file of the periodic task timer.
`default_nettype none
module ptt_regs
    import ptt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;

    assign idx = paddr[5:3];
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (idx)
                REG_START:    cfg_next.start_time      = pwdata[TIME_W-1:0];
                REG_INTERVAL: cfg_next.repeat_interval = pwdata[TIME_W-1:0];
                REG_COUNT:    cfg_next.repeat_count    = pwdata[RCNT_W-1:0];
                REG_FOREVER:  cfg_next.repeat_forever  = pwdata[0];
                REG_POLICY:   cfg_next.missed_policy   = pwdata[1:0];
                REG_WARN:     cfg_next.warning_slop    = pwdata[TIME_W-1:0];
                REG_FAIL:     cfg_next.fail_slop       = pwdata[TIME_W-1:0];
                REG_WEN:      cfg_next.warnings_enable = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_START:    prdata = DATA_W'(cfg_reg.start_time);
            REG_INTERVAL: prdata = DATA_W'(cfg_reg.repeat_interval);
            REG_COUNT:    prdata = DATA_W'(cfg_reg.repeat_count);
            REG_FOREVER:  prdata = DATA_W'(cfg_reg.repeat_forever);
            REG_POLICY:   prdata = DATA_W'(cfg_reg.missed_policy);
            REG_WARN:     prdata = DATA_W'(cfg_reg.warning_slop);
            REG_FAIL:     prdata = DATA_W'(cfg_reg.fail_slop);
            REG_WEN:      prdata = DATA_W'(cfg_reg.warnings_enable);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg              <= '0;
            cfg_reg.start_time   <= TIME_W'(1);
            cfg_reg.repeat_count <= RCNT_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/ptt_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ptt_div
    import ptt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [TIME_W-1:0] dividend,
    input  wire logic [TIME_W-1:0] divisor,
    output logic      [TIME_W-1:0] quo,
    output logic      [TIME_W-1:0] rem,
    output logic                   done
);

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] dsr_reg, dsr_next;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;

    assign trial = {rem_reg, quo_reg[TIME_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign quo   = quo_reg;
    assign rem   = rem_reg;
    assign done  = done_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TIME_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[TIME_W]) begin
                rem_next = diff[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end else begin
                rem_next = trial[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule
`default_nettype wire

/* hw/rtl/ptt_datapath.sv */
// Datapath: task state, fire arithmetic, drop division and result register.
`default_nettype none
module ptt_datapath
    import ptt_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int MAX_FIRES  = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire in_t  s_word,
    input  wire cmd_t cmd,
    output stat_t     stat,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_word
);

    localparam int CW = COUNT_BITS;
    localparam int RW = (CW > RCNT_W) ? CW : RCNT_W;
    localparam int SW = ((CW > TIME_W) ? CW : TIME_W) + 1;
    localparam int KW = $clog2(MAX_FIRES + 1);

    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] due_reg, due_next;
    logic [CW-1:0]     fires_reg, fires_next;
    logic              canc_reg, canc_next;
    logic [KW-1:0]     k_reg, k_next;
    out_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_word_reg, m_word_next;

    logic [TIME_W-1:0] late;
    logic [1:0]        cls;
    logic [CW-1:0]     fires_inc;
    logic              end_now;
    logic [TIME_W:0]   nd_sum;
    logic [TIME_W-1:0] nd_sat;
    logic              behind;
    logic              div_go;
    logic [TIME_W-1:0] quo;
    logic [TIME_W-1:0] rem;
    logic              div_done;
    logic [SW-1:0]     cadd;
    logic [DROP_W-1:0] dropped;
    logic              cond;
    logic              out_free;

    assign late = now_reg - due_reg;

    always_comb begin
        if (cfg.warnings_enable && cfg.fail_slop != '0 && late > cfg.fail_slop) begin
            cls = CLASS_ERR;
        end else if (cfg.warnings_enable && cfg.warning_slop != '0 &&
                     late > cfg.warning_slop) begin
            cls = CLASS_WARN;
        end else begin
            cls = CLASS_OK;
        end
    end

    assign fires_inc = (fires_reg == '1) ? fires_reg : fires_reg + CW'(1);
    assign end_now   = (!cfg.repeat_forever &&
                        RW'(fires_inc) >= RW'(cfg.repeat_count)) || canc_reg;
    assign nd_sum    = {1'b0, due_reg} + {1'b0, cfg.repeat_interval};
    assign nd_sat    = nd_sum[TIME_W] ? '1 : nd_sum[TIME_W-1:0];
    assign behind    = (now_reg > due_reg) && (late > cfg.repeat_interval);
    assign div_go    = (res_reg.end_reason == END_RUN) && behind &&
                       (cfg.missed_policy == POL_DROP) && (cfg.repeat_interval != '0);

    ptt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.check && div_go),
        .dividend (late),
        .divisor  (cfg.repeat_interval),
        .quo      (quo),
        .rem      (rem),
        .done     (div_done)
    );

    assign cadd    = SW'(fires_reg) + SW'(quo);
    assign dropped = (|quo[TIME_W-1:DROP_W]) ? '1 : quo[DROP_W-1:0];

    assign cond     = (due_reg != '0) && (due_reg <= now_reg) && (k_reg < KW'(MAX_FIRES));
    assign out_free = !m_valid_reg || m_ready;

    assign stat.cond     = cond;
    assign stat.div_go   = div_go;
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;
    assign stat.last     = res_reg.last_fire;

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    always_comb begin
        now_next     = now_reg;
        due_next     = due_reg;
        fires_next   = fires_reg;
        canc_next    = canc_reg;
        k_next       = k_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;

        if (cmd.accept) begin
            case (s_word.kind)
                KIND_TICK: begin
                    now_next = s_word.now_time;
                    k_next   = '0;
                end
                KIND_CANCEL: canc_next = 1'b1;
                KIND_RESTART: begin
                    due_next   = cfg.start_time;
                    fires_next = '0;
                    canc_next  = 1'b0;
                end
                default: ;
            endcase
        end

        if (cmd.fire) begin
            res_next            = '0;
            res_next.lateness   = late;
            res_next.late_class = cls;
            fires_next          = fires_inc;
            k_next              = k_reg + KW'(1);
            if (end_now) begin
                due_next            = '0;
                res_next.end_reason = END_DONE;
            end else begin
                due_next = nd_sat;
            end
        end

        if (cmd.check && res_reg.end_reason == END_RUN && behind &&
            cfg.missed_policy == POL_TERM) begin
            due_next            = '0;
            res_next.end_reason = END_BEHIND;
        end

        if (cmd.drop) begin
            due_next               = now_reg - rem;
            fires_next             = (cadd > SW'({CW{1'b1}})) ? '1 : cadd[CW-1:0];
            res_next.dropped_count = dropped;
            res_next.drop_warning  = cfg.warnings_enable && (cfg.warning_slop != '0);
        end

        if (cmd.eval) begin
            res_next.next_due  = due_reg;
            res_next.last_fire = !cond;
        end

        if (cmd.emit && out_free) begin
            m_valid_next = 1'b1;
            m_word_next  = res_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            due_reg     <= '0;
            fires_reg   <= '0;
            canc_reg    <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            due_reg     <= due_next;
            fires_reg   <= fires_next;
            canc_reg    <= canc_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
        now_reg    <= now_next;
        res_reg    <= res_next;
        m_word_reg <= m_word_next;
    end

endmodule
`default_nettype wire

/* hw/rtl/ptt_ctrl.sv */
// Controller state machine sequencing one input word through the datapath.
`default_nettype none
module ptt_ctrl
    import ptt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] kind,
    input  wire stat_t      stat,
    output cmd_t            cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TEST  = 3'd1;
    localparam logic [2:0] ST_FIRE  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DROP  = 3'd5;
    localparam logic [2:0] ST_EVAL  = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0] state_reg, state_next;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.accept = s_valid && s_ready;
    assign cmd.fire   = (state_reg == ST_FIRE);
    assign cmd.check  = (state_reg == ST_CHECK);
    assign cmd.drop   = (state_reg == ST_DROP);
    assign cmd.eval   = (state_reg == ST_EVAL);
    assign cmd.emit   = (state_reg == ST_EMIT);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && kind == KIND_TICK) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:  state_next = stat.cond ? ST_FIRE : ST_IDLE;
            ST_FIRE:  state_next = ST_CHECK;
            ST_CHECK: state_next = stat.div_go ? ST_DIV : ST_EVAL;
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_DROP;
                end
            end
            ST_DROP:  state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = stat.last ? ST_IDLE : ST_FIRE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/periodic_task_timer.sv */
// Top level of the periodic task timer.
// One input word at a time: cancel, restart and unused kinds stay in IDLE;
// a tick passes TEST and, per fire (at most MAX_FIRES), FIRE, CHECK, EVAL
// and EMIT, with DIV and DROP after CHECK when the drop policy skips missed
// intervals; the skip count comes from a restoring divider that makes one
// quotient bit per cycle over the 48-bit time. A fire also waits while the
// output register still holds an untaken result. Configuration is written
// over APB with pready always high; registers sit at byte address 8*index.
`default_nettype none
module periodic_task_timer
    import ptt_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int MAX_FIRES  = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_t               s_word,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_t                   m_word,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    assign pready = 1'b1;

    ptt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ptt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .kind    (s_word.kind),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptt_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .MAX_FIRES  (MAX_FIRES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_word  (s_word),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule
`default_nettype wire

/* hw/rtl/ptt_checker.sv */
// Port-level checker of the periodic task timer and its bind.
`default_nettype none
module ptt_checker
    import ptt_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_word
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("stalled result word changed");

    a_end_due: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_word.end_reason == END_RUN) == (m_word.next_due != '0)))
        else $error("end reason and next due disagree");

    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word.drop_warning || m_word.dropped_count != '0) |->
            (m_word.dropped_count != '0) && (m_word.end_reason == END_RUN))
        else $error("drop reported without skipped intervals on a running task");

endmodule

bind periodic_task_timer ptt_checker u_ptt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
`default_nettype wire

/* sim/tb_periodic_task_timer.sv */
// Self-checking testbench for the periodic task timer: directed and random words.
`timescale 1ns / 1ps
module tb_periodic_task_timer;
    import ptt_pkg::*;

    localparam int          FIRE_CNT_W    = 32;
    localparam int          FIRE_CAP      = 16;
    localparam logic [63:0] TIME_MAX      = (64'd1 << TIME_W) - 64'd1;
    localparam logic [63:0] FIRES_MAX     = (64'd1 << FIRE_CNT_W) - 64'd1;
    localparam logic [63:0] DROP_MAX      = (64'd1 << DROP_W) - 64'd1;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;
    localparam logic [1:0]  POL_UNUSED    = 2'd3;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          RUN_LIMIT     = 1000000;
    localparam int          SEG_WORDS     = 16;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_t               s_word  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_t              m_word;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    in_t         cmd_words[$];
    out_t        pending_fires[$];
    cfg_t        cfg;
    logic [63:0] due_at      = '0;
    logic [63:0] fire_total  = '0;
    logic        cancel_pend = 1'b0;
    int          bad_count   = 0;
    int          cycle_no    = 0;
    int          send_idle   = 0;
    int          recv_idle   = 0;
    int          hold_left   = 0;
    logic        word_taken  = 1'b0;
    logic        hold_arm    = 1'b0;
    logic        hold_taken  = 1'b0;

    periodic_task_timer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 aclk = ~aclk;

    function automatic logic [63:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v & TIME_MAX;
    endfunction

    function automatic logic [63:0] sat_fires(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a || s > FIRES_MAX) ? FIRES_MAX : s;
    endfunction

    function automatic void note_bad(string msg);
        bad_count++;
        if (bad_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic string fire_str(out_t f);
        return $sformatf("late=%0d cls=%0d drop=%0d dw=%0d end=%0d next=%0d last=%0d",
                         f.lateness, f.late_class, f.dropped_count, f.drop_warning,
                         f.end_reason, f.next_due, f.last_fire);
    endfunction

    function automatic cfg_t mk_cfg(logic [63:0] start, logic [63:0] intv, logic [31:0] cnt,
                                    logic rep_all, logic [1:0] pol, logic [63:0] warn,
                                    logic [63:0] fail, logic wen);
        cfg_t c;
        c.start_time      = start[TIME_W-1:0];
        c.repeat_interval = intv[TIME_W-1:0];
        c.repeat_count    = cnt;
        c.repeat_forever  = rep_all;
        c.missed_policy   = pol;
        c.warning_slop    = warn[TIME_W-1:0];
        c.fail_slop       = fail[TIME_W-1:0];
        c.warnings_enable = wen;
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(cfg_t c, int idx);
        case (idx)
            REG_START:    return DATA_W'(c.start_time);
            REG_INTERVAL: return DATA_W'(c.repeat_interval);
            REG_COUNT:    return DATA_W'(c.repeat_count);
            REG_FOREVER:  return DATA_W'(c.repeat_forever);
            REG_POLICY:   return DATA_W'(c.missed_policy);
            REG_WARN:     return DATA_W'(c.warning_slop);
            REG_FAIL:     return DATA_W'(c.fail_slop);
            REG_WEN:      return DATA_W'(c.warnings_enable);
            default:      return '0;
        endcase
    endfunction

    function automatic void queue_word(logic [1:0] kind, logic [63:0] at);
        in_t w;
        w.kind     = kind;
        w.now_time = at[TIME_W-1:0];
        cmd_words.push_back(w);
    endfunction

    // Fires caused by one accepted word, in order, appended to pending_fires.
    function automatic void compute_fires(in_t w);
        logic [63:0] now, late, nd, skips;
        int          n;
        out_t        r;
        now = 64'(w.now_time);
        case (w.kind)
            KIND_CANCEL: cancel_pend = 1'b1;
            KIND_RESTART: begin
                due_at      = 64'(cfg.start_time);
                fire_total  = '0;
                cancel_pend = 1'b0;
            end
            KIND_TICK: begin
                n = 0;
                while (due_at != 0 && due_at <= now && n < FIRE_CAP) begin
                    r            = '0;
                    r.late_class = CLASS_OK;
                    r.end_reason = END_RUN;
                    late         = now - due_at;
                    r.lateness   = late[TIME_W-1:0];
                    if (cfg.warnings_enable) begin
                        if (cfg.fail_slop != 0 && late > cfg.fail_slop) begin
                            r.late_class = CLASS_ERR;
                        end else if (cfg.warning_slop != 0 && late > cfg.warning_slop) begin
                            r.late_class = CLASS_WARN;
                        end
                    end
                    fire_total = sat_fires(fire_total, 64'd1);
                    if ((!cfg.repeat_forever && fire_total >= cfg.repeat_count) || cancel_pend) begin
                        due_at       = '0;
                        r.end_reason = END_DONE;
                    end else begin
                        nd     = due_at + cfg.repeat_interval;
                        due_at = (nd > TIME_MAX) ? TIME_MAX : nd;
                        if (now > due_at && (now - due_at) > cfg.repeat_interval) begin
                            if (cfg.missed_policy == POL_TERM) begin
                                due_at       = '0;
                                r.end_reason = END_BEHIND;
                            end else if (cfg.missed_policy == POL_DROP &&
                                         cfg.repeat_interval != 0) begin
                                skips           = (now - due_at) / cfg.repeat_interval;
                                fire_total      = sat_fires(fire_total, skips);
                                due_at          = due_at + skips * cfg.repeat_interval;
                                r.dropped_count = (skips > DROP_MAX) ? '1 : skips[DROP_W-1:0];
                                r.drop_warning  = cfg.warnings_enable && (cfg.warning_slop != 0);
                            end
                        end
                    end
                    r.next_due = due_at[TIME_W-1:0];
                    pending_fires.push_back(r);
                    n++;
                end
                if (n > 0) begin
                    r           = pending_fires.pop_back();
                    r.last_fire = 1'b1;
                    pending_fires.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_fire(out_t got);
        out_t want;
        if (pending_fires.size() == 0) begin
            note_bad({"unpredicted fire word: ", fire_str(got)});
        end else begin
            want = pending_fires.pop_front();
            if (got !== want) begin
                note_bad({"fire word mismatch, exp ", fire_str(want), " | got ", fire_str(got)});
            end
        end
    endfunction

    task automatic apb_xfer(input logic wr, input int idx, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(idx << 3);
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_regs();
        logic [DATA_W-1:0] got;
        for (int i = REG_START; i <= REG_WEN; i++) begin
            apb_xfer(1'b0, i, '0, got);
            if (got !== reg_value(cfg, i)) begin
                note_bad($sformatf("register %0d read %h, exp %h", i, got, reg_value(cfg, i)));
            end
        end
    endtask

    task automatic set_cfg(cfg_t c);
        logic [DATA_W-1:0] unused_rd;
        cfg = c;
        for (int i = REG_START; i <= REG_WEN; i++) begin
            apb_xfer(1'b1, i, reg_value(c, i), unused_rd);
        end
        check_regs();
    endtask

    task automatic settle();
        while (cmd_words.size() != 0 || s_valid || pending_fires.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly restart followed by ticks creeping past the due times, plus some noise.
    task automatic random_segment(int words);
        cfg_t        c;
        logic [63:0] now, span, base, step;
        int          roll;
        c    = '0;
        roll = $urandom_range(9);
        if (roll == 0) begin
            c.repeat_interval = '0;
        end else if (roll == 1) begin
            c.repeat_interval = TIME_W'(rand_time());
        end else begin
            c.repeat_interval = TIME_W'($urandom_range(1, 60));
        end
        span = (c.repeat_interval == 0 || c.repeat_interval > 1000) ? 64'd50
                                                                     : 64'(c.repeat_interval);
        base = ($urandom_range(2) == 0) ? (rand_time() >> 1) : 64'($urandom_range(1, 300));
        if (base == 0) begin
            base = 64'd1;
        end
        c.start_time      = ($urandom_range(15) == 0) ? '0 : base[TIME_W-1:0];
        c.repeat_count    = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 12);
        c.repeat_forever  = 1'($urandom_range(1));
        c.missed_policy   = 2'($urandom_range(3));
        c.warning_slop    = TIME_W'(($urandom_range(7) == 0) ? rand_time()
                                        : 64'($urandom_range(0, 32'(span))));
        c.fail_slop       = TIME_W'(($urandom_range(7) == 0) ? rand_time()
                                        : 64'($urandom_range(0, 32'(3 * span))));
        c.warnings_enable = ($urandom_range(3) != 0);
        set_cfg(c);
        queue_word(KIND_RESTART, rand_time());
        now = (base > span) ? base - span : 64'd0;
        for (int i = 0; i < words; i++) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                queue_word(KIND_CANCEL, rand_time());
            end else if (roll < 12) begin
                queue_word(KIND_RESTART, rand_time());
            end else if (roll < 18) begin
                queue_word(2'($urandom_range(3)), rand_time());
            end else begin
                step = ($urandom_range(9) == 0) ? span * $urandom_range(5, 40)
                                                : 64'($urandom_range(0, 32'(3 * span)));
                now  = (now + step > TIME_MAX) ? TIME_MAX : now + step;
                queue_word(KIND_TICK, now);
            end
        end
    endtask

    always @(negedge aclk) begin
        if (!s_valid || word_taken) begin
            if (cmd_words.size() != 0 && $urandom_range(99) >= send_idle) begin
                s_word  <= cmd_words.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_arm && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        cycle_no   <= cycle_no + 1;
        word_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            compute_fires(s_word);
        end
        if (aresetn && m_valid && m_ready) begin
            check_fire(m_word);
        end
    end

    initial begin
        while (cycle_no < RUN_LIMIT) @(posedge aclk);
        $display("tb_periodic_task_timer failed");
        $finish;
    end

    initial begin
        cfg       = mk_cfg(64'd1, 64'd0, 32'd1, 1'b0, POL_CATCHUP, 64'd0, 64'd0, 1'b0);
        send_idle = 14;
        recv_idle = 63;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        check_regs();

        // reset settings: inactive task, unused kind, single fire
        queue_word(KIND_TICK, 64'd0);
        queue_word(KIND_UNUSED, TIME_MAX);
        queue_word(KIND_RESTART, 64'd0);
        queue_word(KIND_TICK, 64'd0);
        queue_word(KIND_TICK, 64'd1);
        queue_word(KIND_TICK, TIME_MAX);
        settle();

        // lateness classes and catch up
        set_cfg(mk_cfg(64'd100, 64'd10, 32'd0, 1'b1, POL_CATCHUP, 64'd5, 64'd20, 1'b1));
        queue_word(KIND_RESTART, 64'd0);
        queue_word(KIND_TICK, 64'd100);
        queue_word(KIND_TICK, 64'd117);
        queue_word(KIND_TICK, 64'd150);
        settle();

        // zero interval with drop: nothing skipped, fire cap, cancel
        set_cfg(mk_cfg(64'd5, 64'd0, 32'd3, 1'b1, POL_DROP, 64'd0, 64'd0, 1'b0));
        queue_word(KIND_RESTART, 64'd0);
        queue_word(KIND_TICK, 64'd9);
        queue_word(KIND_CANCEL, 64'd0);
        queue_word(KIND_TICK, 64'd9);
        settle();

        // terminate on falling behind
        set_cfg(mk_cfg(64'd1000, 64'd100, 32'd100, 1'b0, POL_TERM, 64'd0, 64'd0, 1'b0));
        queue_word(KIND_RESTART, 64'd0);
        queue_word(KIND_TICK, 64'd1350);
        queue_word(KIND_RESTART, 64'd0);
        queue_word(KIND_TICK, 64'd1000);
        settle();

        // drop missed intervals, count reached by the skip
        set_cfg(mk_cfg(64'd1000, 64'd100, 32'd5, 1'b0, POL_DROP, 64'd1, 64'd0, 1'b1));
        queue_word(KIND_RESTART, 64'd0);
        queue_word(KIND_TICK, 64'd1950);
        settle();

        // due time saturates, unused policy
        set_cfg(mk_cfg(TIME_MAX, TIME_MAX, 32'hFFFF_FFFF, 1'b1, POL_UNUSED, TIME_MAX, TIME_MAX,
                       1'b1));
        queue_word(KIND_RESTART, 64'd0);
        queue_word(KIND_TICK, TIME_MAX);
        settle();

        // huge skip: fire counter and dropped count saturate
        set_cfg(mk_cfg(64'd1, 64'd1, 32'hFFFF_FFFF, 1'b0, POL_DROP, TIME_MAX, 64'd1, 1'b1));
        queue_word(KIND_RESTART, 64'd0);
        queue_word(KIND_TICK, TIME_MAX);
        settle();

        // zero start time keeps the task inactive
        set_cfg(mk_cfg(64'd0, 64'd7, 32'd1, 1'b0, POL_CATCHUP, 64'd0, 64'd0, 1'b0));
        queue_word(KIND_RESTART, 64'd0);
        queue_word(KIND_TICK, 64'd50);
        settle();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 14 : (mode == 1) ? 63 : 0;
            recv_idle = (mode == 0) ? 63 : (mode == 1) ? 14 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                random_segment(SEG_WORDS);
                if (mode == 2 && seg == 0) begin
                    hold_arm = 1'b1;
                end
                settle();
            end
        end

        if (bad_count == 0) begin
            $display("tb_periodic_task_timer passed");
        end else begin
            $display("tb_periodic_task_timer failed");
        end
        $finish;
    end

endmodule

/* periodic_task_timer.f */
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_regs.sv
hw/rtl/ptt_div.sv
hw/rtl/ptt_datapath.sv
hw/rtl/ptt_ctrl.sv
hw/rtl/periodic_task_timer.sv
hw/rtl/ptt_checker.sv
sim/tb_periodic_task_timer.sv
